FILE: hdl/slt_pkg.sv
// Shared types, token codes and keyword tables for the script lexical tokenizer.
// Depends on nothing; imported by script_lexical_tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package slt_pkg;

	// Counter widths.
	localparam int LINE_BITS     = 24;
	localparam int POSITION_BITS = 24;
	localparam int OUT_BITS      = 24;

	typedef logic [LINE_BITS-1:0]     line_t;
	typedef logic [POSITION_BITS-1:0] pos_t;

	// Token kinds.
	localparam logic [5:0] KIND_IDENT  = 6'd0;
	localparam logic [5:0] KIND_INT    = 6'd1;
	localparam logic [5:0] KIND_REAL   = 6'd2;
	localparam logic [5:0] KIND_STRING = 6'd3;
	localparam logic [5:0] KIND_KW0    = 6'd4;
	localparam logic [5:0] KIND_OR     = 6'd11;
	localparam logic [5:0] KIND_AND    = 6'd12;
	localparam logic [5:0] KIND_PLUS   = 6'd13;
	localparam logic [5:0] KIND_MINUS  = 6'd14;
	localparam logic [5:0] KIND_STAR   = 6'd15;
	localparam logic [5:0] KIND_SLASH  = 6'd16;
	localparam logic [5:0] KIND_PCT    = 6'd17;
	localparam logic [5:0] KIND_NOT    = 6'd18;
	localparam logic [5:0] KIND_NE     = 6'd19;
	localparam logic [5:0] KIND_LPAREN = 6'd20;
	localparam logic [5:0] KIND_RPAREN = 6'd21;
	localparam logic [5:0] KIND_LBRACE = 6'd22;
	localparam logic [5:0] KIND_RBRACE = 6'd23;
	localparam logic [5:0] KIND_SEMI   = 6'd24;
	localparam logic [5:0] KIND_ASSIGN = 6'd25;
	localparam logic [5:0] KIND_COMMA  = 6'd26;
	localparam logic [5:0] KIND_LT     = 6'd27;
	localparam logic [5:0] KIND_LE     = 6'd28;
	localparam logic [5:0] KIND_GT     = 6'd29;
	localparam logic [5:0] KIND_GE     = 6'd30;
	localparam logic [5:0] KIND_ERROR  = 6'd31;
	localparam logic [5:0] KIND_EOF    = 6'd32;

	// Error causes.
	localparam logic [1:0] CAUSE_NONE      = 2'd0;
	localparam logic [1:0] CAUSE_UNCLOSED  = 2'd1;
	localparam logic [1:0] CAUSE_MALFORMED = 2'd2;
	localparam logic [1:0] CAUSE_UNKNOWN   = 2'd3;

	// Characters with a role in the scanner.
	localparam logic [15:0] CH_NL    = 16'h000a;
	localparam logic [15:0] CH_SPACE = 16'h0020;
	localparam logic [15:0] CH_QUOTE = 16'h0022;
	localparam logic [15:0] CH_DOT   = 16'h002e;
	localparam logic [15:0] CH_SLASH = 16'h002f;
	localparam logic [15:0] CH_BANG  = 16'h0021;
	localparam logic [15:0] CH_LT    = 16'h003c;
	localparam logic [15:0] CH_EQ    = 16'h003d;
	localparam logic [15:0] CH_GT    = 16'h003e;
	localparam logic [15:0] CH_UNDER = 16'h005f;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_IDENT   = 3'd1,
		MODE_NUMBER  = 3'd2,
		MODE_STRING  = 3'd3,
		MODE_COMMENT = 3'd4,
		MODE_OPER    = 3'd5
	} scan_mode_t;

	typedef enum logic [2:0] {
		PEND_NONE  = 3'd0,
		PEND_SLASH = 3'd1,
		PEND_BANG  = 3'd2,
		PEND_LT    = 3'd3,
		PEND_GT    = 3'd4
	} pend_t;

	localparam int NUM_KW = 7;

	// Keywords: if, while, else, break, return, var, function.
	localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
		'{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h77, 8'h68, 8'h69, 8'h6c, 8'h65, 8'h00, 8'h00, 8'h00},
		'{8'h65, 8'h6c, 8'h73, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h62, 8'h72, 8'h65, 8'h61, 8'h6b, 8'h00, 8'h00, 8'h00},
		'{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6e, 8'h00, 8'h00},
		'{8'h76, 8'h61, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h66, 8'h75, 8'h6e, 8'h63, 8'h74, 8'h69, 8'h6f, 8'h6e}
	};
	localparam logic [3:0] KW_LEN [NUM_KW] = '{4'd2, 4'd5, 4'd4, 4'd5, 4'd6, 4'd3, 4'd8};

	// Scanner state for the token being built.
	typedef struct packed {
		scan_mode_t          mode;
		line_t               tline;
		pos_t                tstart;
		pos_t                tlen;
		logic [1:0]          dots;
		logic                last_dot;
		logic [NUM_KW-1:0]   cand;
		pend_t               pend;
	} scan_t;

	// One result item.
	typedef struct packed {
		logic [5:0]          kind;
		logic [1:0]          cause;
		logic [OUT_BITS-1:0] line;
		logic [OUT_BITS-1:0] start;
		logic [OUT_BITS-1:0] len;
		logic                last;
	} res_t;

	function automatic line_t line_inc(line_t v);
		return (v == '1) ? v : line_t'(v + 1'b1);
	endfunction

	function automatic pos_t pos_inc(pos_t v);
		return (v == '1) ? v : pos_t'(v + 1'b1);
	endfunction

	function automatic res_t mk_res(logic [5:0] kind, logic [1:0] cause, line_t line,
			pos_t start, pos_t len);
		res_t r;
		r.kind  = kind;
		r.cause = cause;
		r.line  = OUT_BITS'(line);
		r.start = OUT_BITS'(start);
		r.len   = OUT_BITS'(len);
		r.last  = 1'b0;
		return r;
	endfunction

	// Keywords whose character at offset idx equals c.
	function automatic logic [NUM_KW-1:0] kw_match(pos_t idx, logic [15:0] c);
		logic [NUM_KW-1:0] m;
		for (int k = 0; k < NUM_KW; k++) begin
			m[k] = (idx < pos_t'(KW_LEN[k])) && (c == {8'h00, KW_TEXT[k][idx[2:0]]});
		end
		return m;
	endfunction

	// Kind of a character that is a complete operator by itself.
	function automatic logic [5:0] single_kind(logic [15:0] c);
		case (c)
			16'h007c: return KIND_OR;
			16'h0026: return KIND_AND;
			16'h002b: return KIND_PLUS;
			16'h002d: return KIND_MINUS;
			16'h002a: return KIND_STAR;
			16'h0025: return KIND_PCT;
			16'h0028: return KIND_LPAREN;
			16'h0029: return KIND_RPAREN;
			16'h007b: return KIND_LBRACE;
			16'h007d: return KIND_RBRACE;
			16'h003b: return KIND_SEMI;
			16'h003d: return KIND_ASSIGN;
			16'h002c: return KIND_COMMA;
			default:  return KIND_ERROR;
		endcase
	endfunction

endpackage

`default_nettype wire

FILE: hdl/script_lexical_tokenizer.sv
// Streaming lexical tokenizer: one character per item in, tokens out.
// Depends on slt_pkg (types, token codes, keyword tables).
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload (lowest bit first)                       Marker
// s_*       in         tdata: char_code[15:0]                           tlast: end_of_text
// m_*       out        tuser: token_kind[5:0], error_cause[7:6]         tlast: last_of_run
//                      tdata: line_number[23:0], start_position[47:24],
//                             token_length[71:48]
//
// Cycles: each accepted character is scanned in the cycle it is accepted; its
// zero, one or two tokens land in a four-entry result queue and, while m_tready is
// high, leave at one token per cycle; sustained rate is then one item per cycle while
// items make at most one token each; the single output port sets the limit when they
// make two. Reset (arst_n low) returns the scanner to line 1, offset 0, and empties
// the queue. s_tready drops while the queue holds more than two tokens, so an item
// with two tokens always finds room; m_tready low only fills the queue.

module script_lexical_tokenizer
	import slt_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire [15:0] s_tdata,   // char_code[15:0]
	input  wire        s_tlast,   // end_of_text
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [71:0] m_tdata,  // line_number, start_position, token_length
	output logic [7:0] m_tuser,   // token_kind[5:0], error_cause[7:6]
	output logic       m_tlast    // last_of_run
);

	localparam int QDEPTH = 4;

	localparam scan_t SCAN_RESET = '{
		mode:     MODE_IDLE,
		tline:    line_t'(1),
		tstart:   '0,
		tlen:     '0,
		dots:     2'd0,
		last_dot: 1'b0,
		cand:     '1,
		pend:     PEND_NONE
	};

	// Scanner state.
	scan_t scan_q;
	line_t line_q;
	pos_t  pos_q;

	// Result queue.
	res_t       queue_q [QDEPTH];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] count_q;

	logic [15:0] c;
	logic        accept;
	logic        pop;

	logic is_space, is_alpha, is_digit, is_word;

	// Outcome of a character seen with no token open.
	scan_t idle_scan;
	logic  idle_emit;
	res_t  idle_res;

	// Token closed by this item (flush) and one more token (other).
	logic  flush_v, other_v;
	res_t  flush_res, other_res;
	logic  [5:0] ident_kind;
	logic  [1:0] num_res;
	res_t  res0, res1;

	scan_t scan_d;
	line_t line_d;
	pos_t  pos_d;

	assign c = s_tdata;

	assign is_space = (c == CH_SPACE) || (c >= 16'd9 && c <= 16'd13);
	assign is_alpha = (c >= 16'h0041 && c <= 16'h005a) || (c >= 16'h0061 && c <= 16'h007a);
	assign is_digit = (c >= 16'h0030 && c <= 16'h0039);
	assign is_word  = is_alpha || is_digit || (c == CH_UNDER);

	// Start of a new token from idle.
	always_comb begin
		idle_scan      = scan_q;
		idle_scan.mode = MODE_IDLE;
		idle_emit      = 1'b0;
		idle_res       = mk_res(single_kind(c), CAUSE_NONE, line_q, pos_q, pos_t'(1));
		if (!is_space) begin
			idle_scan.tline  = line_q;
			idle_scan.tstart = pos_q;
			if (is_alpha || c == CH_UNDER) begin
				idle_scan.mode = MODE_IDENT;
				idle_scan.cand = kw_match('0, c);
				idle_scan.tlen = pos_t'(1);
			end else if (is_digit) begin
				idle_scan.mode     = MODE_NUMBER;
				idle_scan.dots     = 2'd0;
				idle_scan.last_dot = 1'b0;
				idle_scan.tlen     = pos_t'(1);
			end else if (c == CH_QUOTE) begin
				idle_scan.mode   = MODE_STRING;
				idle_scan.tstart = pos_inc(pos_q);
				idle_scan.tlen   = '0;
			end else if (c == CH_SLASH || c == CH_BANG || c == CH_LT || c == CH_GT) begin
				idle_scan.mode = MODE_OPER;
				if (c == CH_SLASH) begin
					idle_scan.pend = PEND_SLASH;
				end else if (c == CH_BANG) begin
					idle_scan.pend = PEND_BANG;
				end else if (c == CH_LT) begin
					idle_scan.pend = PEND_LT;
				end else begin
					idle_scan.pend = PEND_GT;
				end
			end else begin
				idle_emit = 1'b1;
				if (idle_res.kind == KIND_ERROR) begin
					idle_res.cause = CAUSE_UNKNOWN;
				end
			end
		end
	end

	// Kind of the open identifier; keyword lengths differ where it matters.
	always_comb begin
		ident_kind = KIND_IDENT;
		for (int k = NUM_KW - 1; k >= 0; k--) begin
			if (scan_q.cand[k] && scan_q.tlen == pos_t'(KW_LEN[k])) begin
				ident_kind = KIND_KW0 + 6'(k);
			end
		end
	end

	// Token that the open mode yields when it is closed.
	always_comb begin
		flush_res = mk_res(ident_kind, CAUSE_NONE, scan_q.tline, scan_q.tstart, scan_q.tlen);
		case (scan_q.mode)
			MODE_NUMBER: begin
				if (scan_q.dots == 2'd0) begin
					flush_res.kind = KIND_INT;
				end else if (scan_q.dots == 2'd1 && !scan_q.last_dot) begin
					flush_res.kind = KIND_REAL;
				end else begin
					flush_res.kind  = KIND_ERROR;
					flush_res.cause = CAUSE_MALFORMED;
				end
			end
			MODE_STRING: begin
				flush_res.kind  = KIND_ERROR;
				flush_res.cause = CAUSE_UNCLOSED;
			end
			MODE_OPER: begin
				flush_res.len = OUT_BITS'(1);
				case (scan_q.pend)
					PEND_BANG: flush_res.kind = KIND_NOT;
					PEND_LT:   flush_res.kind = KIND_LT;
					PEND_GT:   flush_res.kind = KIND_GT;
					default:   flush_res.kind = KIND_SLASH;
				endcase
			end
			default: ;
		endcase
	end

	// Next state and the tokens of this item.
	always_comb begin
		scan_d    = scan_q;
		line_d    = line_q;
		pos_d     = pos_inc(pos_q);
		flush_v   = 1'b0;
		other_v   = 1'b0;
		other_res = idle_res;
		if (c == CH_NL) begin
			line_d = line_inc(line_q);
		end

		if (s_tlast) begin
			// End of text: close what is open, mark eof, start over.
			flush_v   = (scan_q.mode == MODE_IDENT) || (scan_q.mode == MODE_NUMBER) ||
			            (scan_q.mode == MODE_STRING) || (scan_q.mode == MODE_OPER);
			other_v   = 1'b1;
			other_res = mk_res(KIND_EOF, CAUSE_NONE, line_q, pos_q, '0);
			scan_d    = SCAN_RESET;
			line_d    = line_t'(1);
			pos_d     = '0;
		end else begin
			case (scan_q.mode)
				MODE_IDENT: begin
					if (is_word) begin
						scan_d.cand = scan_q.cand & kw_match(scan_q.tlen, c);
						scan_d.tlen = pos_inc(scan_q.tlen);
					end else begin
						flush_v = 1'b1;
						scan_d  = idle_scan;
						other_v = idle_emit;
					end
				end
				MODE_NUMBER: begin
					if (is_digit || c == CH_DOT) begin
						if (c == CH_DOT && scan_q.dots != 2'd2) begin
							scan_d.dots = scan_q.dots + 2'd1;
						end
						scan_d.last_dot = (c == CH_DOT);
						scan_d.tlen     = pos_inc(scan_q.tlen);
					end else begin
						flush_v = 1'b1;
						scan_d  = idle_scan;
						other_v = idle_emit;
					end
				end
				MODE_STRING: begin
					if (c == CH_QUOTE) begin
						other_v     = 1'b1;
						other_res   = mk_res(KIND_STRING, CAUSE_NONE, scan_q.tline,
						                     scan_q.tstart, scan_q.tlen);
						scan_d.mode = MODE_IDLE;
					end else begin
						scan_d.tlen = pos_inc(scan_q.tlen);
					end
				end
				MODE_COMMENT: begin
					if (c == CH_NL) begin
						scan_d.mode = MODE_IDLE;
					end
				end
				MODE_OPER: begin
					if (scan_q.pend == PEND_SLASH && c == CH_SLASH) begin
						scan_d.mode = MODE_COMMENT;
					end else if (scan_q.pend != PEND_SLASH && c == CH_EQ) begin
						other_v     = 1'b1;
						other_res   = mk_res(KIND_GE, CAUSE_NONE, scan_q.tline,
						                     scan_q.tstart, pos_t'(2));
						if (scan_q.pend == PEND_BANG) begin
							other_res.kind = KIND_NE;
						end else if (scan_q.pend == PEND_LT) begin
							other_res.kind = KIND_LE;
						end
						scan_d.mode = MODE_IDLE;
					end else begin
						flush_v = 1'b1;
						scan_d  = idle_scan;
						other_v = idle_emit;
					end
					if (scan_d.mode != MODE_OPER) begin
						scan_d.pend = PEND_NONE;
					end
				end
				default: begin
					scan_d  = idle_scan;
					other_v = idle_emit;
				end
			endcase
		end
	end

	// Order the tokens: a closed token always precedes the new one.
	always_comb begin
		res0 = flush_v ? flush_res : other_res;
		res1 = other_res;
		num_res = {1'b0, flush_v} + {1'b0, other_v};
		res0.last = (num_res == 2'd1);
		res1.last = 1'b1;
	end

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (count_q <= 3'd2);
	assign m_tvalid = (count_q != 3'd0);
	assign pop      = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= SCAN_RESET;
			line_q <= line_t'(1);
			pos_q  <= '0;
		end else if (accept) begin
			scan_q <= scan_d;
			line_q <= line_d;
			pos_q  <= pos_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q  <= 3'd0;
		end else begin
			wr_ptr_q <= wr_ptr_q + (accept ? num_res : 2'd0);
			rd_ptr_q <= rd_ptr_q + {1'b0, pop};
			count_q  <= count_q + (accept ? {1'b0, num_res} : 3'd0) - {2'b00, pop};
		end
	end

	// Queue payload, no reset.
	always_ff @(posedge clk) begin
		if (accept && num_res != 2'd0) begin
			queue_q[wr_ptr_q] <= res0;
		end
		if (accept && num_res == 2'd2) begin
			queue_q[wr_ptr_q + 2'd1] <= res1;
		end
	end

	always_comb begin
		m_tuser = {queue_q[rd_ptr_q].cause, queue_q[rd_ptr_q].kind};
		m_tdata = {queue_q[rd_ptr_q].len, queue_q[rd_ptr_q].start, queue_q[rd_ptr_q].line};
		m_tlast = queue_q[rd_ptr_q].last;
	end

	// Queue never overflows given the ready rule.
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= 3'(QDEPTH))
		else $error("result queue overflow");

	// End of text brings the scanner back to the start of a fresh text.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tlast) |=> (scan_q.mode == MODE_IDLE && line_q == line_t'(1) &&
		                        pos_q == '0))
		else $error("scanner not restarted after end of text");

	// The eof token is always the last token of its item.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[5:0] == KIND_EOF) |-> m_tlast)
		else $error("eof token without last_of_run");

	// Line count starts at one and saturates, so it is never zero.
	assert property (@(posedge clk) disable iff (!arst_n) line_q != '0)
		else $error("line count reached zero");

endmodule

`default_nettype wire

FILE: tb/script_lexical_tokenizer_tb.sv
// Self-checking bench for script_lexical_tokenizer: streams directed and random source text,
// predicts every token from its own scanner model and checks each one field by field.
// Depends on slt_pkg and hdl/script_lexical_tokenizer.sv.
`timescale 1ns / 1ps

module script_lexical_tokenizer_tb;
	import slt_pkg::*;

	localparam int IDLE_LIMIT   = 2000;  // cycles with no item moving on either side
	localparam int SOURCE_ITEMS = 500;
	localparam int TAIL_CYCLES  = 10;

	localparam logic [15:0] CH_TAB     = 16'h0009;
	localparam logic [15:0] CH_CR      = 16'h000d;
	localparam logic [15:0] CH_ZERO    = 16'h0030;
	localparam logic [15:0] CH_UPPER_A = 16'h0041;
	localparam logic [15:0] CH_LOWER_A = 16'h0061;

	typedef struct packed {
		logic [15:0] code;
		logic        eot;
	} src_item_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic [7:0]  m_tuser;
	logic        m_tlast;

	src_item_t src_q[$];      // characters not yet accepted
	res_t      token_q[$];    // tokens predicted, not yet seen
	res_t      step_tokens[$];
	bit        failed      = 1'b0;
	bit        item_taken  = 1'b0;
	int        idle_cycles = 0;
	int        burst_left  = 0;
	int        gap_left    = 0;
	int        rdy_run     = 0;

	// Scanner model state
	scan_mode_t mode;
	line_t      line_cnt;
	pos_t       pos_cnt;
	line_t      tok_line;
	pos_t       tok_start;
	pos_t       tok_len;
	logic [1:0] dots;
	logic       last_dot;
	logic [6:0] cand;
	pend_t      pend;

	string kw_name [7] = '{"if", "while", "else", "break", "return", "var", "function"};

	script_lexical_tokenizer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------- scanner model

	function automatic pos_t pos_sat(pos_t v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic bit is_letter(logic [15:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic bit is_digit(logic [15:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic void clear_scanner();
		mode      = MODE_IDLE;
		line_cnt  = 1;
		pos_cnt   = 0;
		tok_line  = 1;
		tok_start = 0;
		tok_len   = 0;
		dots      = 0;
		last_dot  = 1'b0;
		cand      = '1;
		pend      = PEND_NONE;
	endfunction

	// At most two tokens per character.
	function automatic void add_token(logic [5:0] kind, logic [1:0] cause, line_t ln,
			pos_t st, pos_t len);
		res_t t;
		if (step_tokens.size() >= 2)
			return;
		t.kind  = kind;
		t.cause = cause;
		t.line  = ln;
		t.start = st;
		t.len   = len;
		t.last  = 1'b0;
		step_tokens.push_back(t);
	endfunction

	// Drop keywords that cannot match c at the current offset, then grow the token.
	function automatic void ident_char(logic [15:0] c);
		string w;
		for (int k = 0; k < 7; k++) begin
			w = kw_name[k];
			if (tok_len >= pos_t'(w.len()) || c != 16'(w[tok_len]))
				cand[k] = 1'b0;
		end
		tok_len = pos_sat(tok_len);
	endfunction

	function automatic void close_ident();
		logic [5:0] kind;
		kind = KIND_IDENT;
		for (int k = 6; k >= 0; k--)
			if (cand[k] && tok_len == pos_t'(kw_name[k].len()))
				kind = KIND_KW0 + 6'(k);
		add_token(kind, CAUSE_NONE, tok_line, tok_start, tok_len);
	endfunction

	function automatic void close_number();
		if (dots == 0)
			add_token(KIND_INT, CAUSE_NONE, tok_line, tok_start, tok_len);
		else if (dots == 1 && !last_dot)
			add_token(KIND_REAL, CAUSE_NONE, tok_line, tok_start, tok_len);
		else
			add_token(KIND_ERROR, CAUSE_MALFORMED, tok_line, tok_start, tok_len);
	endfunction

	// Held lookahead character resolved as a one-character operator.
	function automatic void close_pending();
		logic [5:0] kind;
		case (pend)
			PEND_BANG: kind = KIND_NOT;
			PEND_LT:   kind = KIND_LT;
			PEND_GT:   kind = KIND_GT;
			default:   kind = KIND_SLASH;
		endcase
		add_token(kind, CAUSE_NONE, tok_line, tok_start, 1);
	endfunction

	function automatic logic [5:0] op_kind(logic [15:0] c);
		case (c)
			"|":     return KIND_OR;
			"&":     return KIND_AND;
			"+":     return KIND_PLUS;
			"-":     return KIND_MINUS;
			"*":     return KIND_STAR;
			"%":     return KIND_PCT;
			"(":     return KIND_LPAREN;
			")":     return KIND_RPAREN;
			"{":     return KIND_LBRACE;
			"}":     return KIND_RBRACE;
			";":     return KIND_SEMI;
			"=":     return KIND_ASSIGN;
			",":     return KIND_COMMA;
			default: return KIND_ERROR;
		endcase
	endfunction

	// A character seen with no token open.
	function automatic void start_token(logic [15:0] c, pos_t p);
		logic [5:0] kind;
		if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
			return;
		tok_line  = line_cnt;
		tok_start = p;
		if (is_letter(c) || c == CH_UNDER) begin
			mode    = MODE_IDENT;
			cand    = '1;
			tok_len = 0;
			ident_char(c);
		end else if (is_digit(c)) begin
			mode     = MODE_NUMBER;
			dots     = 0;
			last_dot = 1'b0;
			tok_len  = 1;
		end else if (c == CH_QUOTE) begin
			// string text starts after the quote
			mode      = MODE_STRING;
			tok_start = pos_sat(p);
			tok_len   = 0;
		end else if (c == CH_SLASH || c == CH_BANG || c == CH_LT || c == CH_GT) begin
			mode = MODE_OPER;
			if (c == CH_SLASH)
				pend = PEND_SLASH;
			else if (c == CH_BANG)
				pend = PEND_BANG;
			else if (c == CH_LT)
				pend = PEND_LT;
			else
				pend = PEND_GT;
		end else begin
			kind = op_kind(c);
			add_token(kind, (kind == KIND_ERROR) ? CAUSE_UNKNOWN : CAUSE_NONE, line_cnt, p, 1);
		end
	endfunction

	// One accepted item: queue the tokens it causes, the last one flagged.
	function automatic void tokenize_char(logic [15:0] c, logic eot);
		pos_t p;
		res_t t;
		p = pos_cnt;
		step_tokens.delete();
		if (eot) begin
			case (mode)
				MODE_IDENT:  close_ident();
				MODE_NUMBER: close_number();
				MODE_STRING: add_token(KIND_ERROR, CAUSE_UNCLOSED, tok_line, tok_start, tok_len);
				MODE_OPER:   close_pending();
				default:     ;  // an open comment ends silently
			endcase
			add_token(KIND_EOF, CAUSE_NONE, line_cnt, pos_cnt, 0);
			clear_scanner();
		end else begin
			case (mode)
				MODE_IDENT: begin
					if (is_letter(c) || is_digit(c) || c == CH_UNDER) begin
						ident_char(c);
					end else begin
						close_ident();
						mode = MODE_IDLE;
						start_token(c, p);
					end
				end
				MODE_NUMBER: begin
					if (is_digit(c) || c == CH_DOT) begin
						if (c == CH_DOT && dots < 2)
							dots++;
						last_dot = (c == CH_DOT);
						tok_len  = pos_sat(tok_len);
					end else begin
						close_number();
						mode = MODE_IDLE;
						start_token(c, p);
					end
				end
				MODE_STRING: begin
					if (c == CH_QUOTE) begin
						add_token(KIND_STRING, CAUSE_NONE, tok_line, tok_start, tok_len);
						mode = MODE_IDLE;
					end else begin
						tok_len = pos_sat(tok_len);
					end
				end
				MODE_COMMENT: begin
					if (c == CH_NL)
						mode = MODE_IDLE;
				end
				MODE_OPER: begin
					if (pend == PEND_SLASH && c == CH_SLASH) begin
						mode = MODE_COMMENT;
					end else if (pend != PEND_SLASH && c == CH_EQ) begin
						add_token((pend == PEND_BANG) ? KIND_NE : (pend == PEND_LT) ? KIND_LE : KIND_GE,
							CAUSE_NONE, tok_line, tok_start, 2);
						mode = MODE_IDLE;
					end else begin
						close_pending();
						mode = MODE_IDLE;
						start_token(c, p);
					end
					// a fresh / ! < > may have taken over the lookahead
					if (mode != MODE_OPER)
						pend = PEND_NONE;
				end
				default: begin
					mode = MODE_IDLE;
					start_token(c, p);
				end
			endcase
			// newline counts exactly once, whatever mode saw it
			if (c == CH_NL && line_cnt != '1)
				line_cnt++;
			pos_cnt = pos_sat(pos_cnt);
		end
		foreach (step_tokens[i]) begin
			t      = step_tokens[i];
			t.last = (i == step_tokens.size() - 1);
			token_q.push_back(t);
		end
	endfunction

	// ---------------------------------------------------------------- stimulus

	task automatic put_char(logic [15:0] c);
		src_q.push_back('{c, 1'b0});
	endtask

	// char_code is a don't-care on end of text, so it carries random bits
	task automatic put_eot();
		src_q.push_back('{16'($urandom_range(0, 65535)), 1'b1});
	endtask

	task automatic put_text(string s);
		for (int i = 0; i < s.len(); i++)
			put_char(16'(s[i]));
	endtask

	function automatic logic [15:0] ident_char_pick(bit first);
		int r;
		r = $urandom_range(0, first ? 52 : 62);
		if (r < 26)
			return CH_LOWER_A + 16'(r);
		if (r < 52)
			return CH_UPPER_A + 16'(r - 26);
		if (r == 52)
			return CH_UNDER;
		return CH_ZERO + 16'(r - 53);
	endfunction

	initial begin
		int          n;
		int          pick;
		string       w;
		logic [15:0] c;

		clear_scanner();

		// Directed: keyword, malformed real, <=, ! resolved by lookahead, comment whose
		// newline must count once, a string, code-space extremes, lone / at end of text,
		// unclosed string, number ending in a dot.
		put_text("if 1.2.3<=!//\n\"s\"");
		put_char(16'hffff);
		put_char(16'h0000);
		put_char(CH_SLASH);
		put_eot();
		put_text("\"a");
		put_eot();
		put_text("1.");
		put_eot();

		// Random: mostly well-formed pieces of source, some noise and broken ones.
		while (src_q.size() < SOURCE_ITEMS) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3: begin
					// keyword, keyword prefix, keyword with a tail, or plain identifier
					w    = kw_name[$urandom_range(0, 6)];
					pick = $urandom_range(0, 3);
					if (pick == 1)
						w = w.substr(0, $urandom_range(0, w.len() - 2));
					if (pick == 3) begin
						put_char(ident_char_pick(1'b1));
						w = "";
					end
					put_text(w);
					if (pick >= 2) begin
						n = $urandom_range(1, 6);
						repeat (n) put_char(ident_char_pick(1'b0));
					end
				end
				4, 5, 6: begin
					put_char(CH_ZERO + 16'($urandom_range(0, 9)));
					n = $urandom_range(0, 7);
					repeat (n) begin
						c = ($urandom_range(0, 4) == 0) ? CH_DOT : CH_ZERO + 16'($urandom_range(0, 9));
						put_char(c);
					end
					if ($urandom_range(0, 5) == 0)
						put_char(CH_DOT);
				end
				7, 8: begin
					put_char(CH_QUOTE);
					n = $urandom_range(0, 8);
					repeat (n) begin
						pick = $urandom_range(0, 15);
						if (pick == 0)
							c = CH_NL;
						else if (pick == 1)
							c = 16'($urandom_range(0, 65535));
						else
							c = 16'($urandom_range(32, 126));
						if (c == CH_QUOTE)
							c = CH_SPACE;
						put_char(c);
					end
					if ($urandom_range(0, 7) != 0)
						put_char(CH_QUOTE);
				end
				9: begin
					put_text("//");
					n = $urandom_range(0, 10);
					repeat (n) put_char(16'($urandom_range(32, 126)));
					if ($urandom_range(0, 9) != 0)
						put_char(CH_NL);
				end
				10, 11, 12, 13: begin
					w = "|&+-*/%!(){};=,<>";
					put_char(16'(w[$urandom_range(0, w.len() - 1)]));
					if ($urandom_range(0, 2) == 0)
						put_char(CH_EQ);
				end
				14, 15: begin
					c = ($urandom_range(0, 6) == 6) ? CH_SPACE : 16'($urandom_range(9, 13));
					put_char(c);
				end
				16: put_char(16'($urandom_range(0, 65535)));
				17: put_eot();
				default: put_char(CH_NL);
			endcase
			if ($urandom_range(0, 1) == 0)
				put_char(CH_SPACE);
		end
		put_eot();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (src_q.size() != 0 || token_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (!failed && token_q.size() == 0)
			$display("script_lexical_tokenizer_tb OK");
		else
			$display("script_lexical_tokenizer_tb NOT OK");
		$finish;
	end

	// ---------------------------------------------------------------- driver

	// Acceptance and prediction at the rising edge.
	always @(posedge clk) begin
		item_taken = arst_n && s_tvalid && s_tready;
		if (item_taken) begin
			tokenize_char(s_tdata, s_tlast);
			void'(src_q.pop_front());
		end
	end

	// Sender: bursts of random length, random gaps between them (some zero).
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || item_taken)) begin
			if (gap_left > 0) begin
				s_tvalid <= 1'b0;
				gap_left--;
			end else if (src_q.size() > 0) begin
				s_tvalid <= 1'b1;
				s_tdata  <= src_q[0].code;
				s_tlast  <= src_q[0].eot;
				if (burst_left == 0)
					burst_left = $urandom_range(1, 24);
				burst_left--;
				if (burst_left == 0) begin
					pick_gap: begin
						int r;
						r = $urandom_range(0, 15);
						gap_left = (r < 5) ? 0 : (r == 15) ? $urandom_range(10, 30) : $urandom_range(1, 6);
					end
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: alternating ready and stall runs, now and then a long ready stretch.
	always @(negedge clk) begin
		if (rdy_run > 0) begin
			rdy_run--;
		end else begin
			m_tready <= !m_tready;
			if (m_tready)
				rdy_run = $urandom_range(0, 3);
			else
				rdy_run = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
		end
	end

	// ---------------------------------------------------------------- monitor

	task automatic check_field(string name, logic [23:0] want, logic [23:0] got);
		if (got !== want) begin
			$display("%0t: token %s mismatch, expected %0d, got %0d", $time, name, want, got);
			failed = 1'b1;
		end
	endtask

	always @(posedge clk) begin : token_check
		res_t got;
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind  = m_tuser[5:0];
			got.cause = m_tuser[7:6];
			got.line  = m_tdata[23:0];
			got.start = m_tdata[47:24];
			got.len   = m_tdata[71:48];
			got.last  = m_tlast;
			if (token_q.size() == 0) begin
				$display("%0t: unexpected token, expected none, got kind %0d line %0d start %0d len %0d",
					$time, got.kind, got.line, got.start, got.len);
				failed = 1'b1;
			end else begin
				want = token_q.pop_front();
				check_field("kind", 24'(want.kind), 24'(got.kind));
				check_field("cause", 24'(want.cause), 24'(got.cause));
				check_field("line", want.line, got.line);
				check_field("start", want.start, got.start);
				check_field("length", want.len, got.len);
				check_field("last", 24'(want.last), 24'(got.last));
			end
		end
	end

	// Watchdog: a hang on either side ends the run.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
			$display("script_lexical_tokenizer_tb NOT OK");
			$finish;
		end
	end

endmodule
